// ===== rtl/rob_pkg.sv =====
package rob_pkg;

    // buffer geometry
    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int TAGX_W = IDX_W + 3;

    // field widths fixed by the interface
    localparam int OP_W   = 3;
    localparam int TAG_W  = 3;
    localparam int DEST_W = 8;
    localparam int VAL_W  = 32;

    localparam logic [DEST_W-1:0] DEST_RESET = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_ISSUE   = 3'd0,
        OP_CAPTURE = 3'd1,
        OP_COMMIT  = 3'd2,
        OP_STEP    = 3'd3,
        OP_LOOKUP  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_RETIRED  = 2'd2
    } t_entry;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

// ===== rtl/reorder_buffer.sv =====
// A request is captured on acceptance, together with a registered read of the
// entry memories; the result register is loaded when the request is executed.
// No new request is taken until the last one has been executed.
// Reset (synchronous, active low) clears head, occupancy, entry states and
// the per-entry written flags at once; no clearing pass is needed.
module reorder_buffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [rob_pkg::OP_W-1:0]     i_op,
    input  logic [rob_pkg::DEST_W-1:0]   i_dest_reg,
    input  logic [rob_pkg::TAG_W-1:0]    i_tag_in,
    input  logic signed [rob_pkg::VAL_W-1:0] i_result_in,
    input  logic                         i_exception_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ok,
    output logic [rob_pkg::TAG_W-1:0]    o_tag_out,
    output logic signed [rob_pkg::VAL_W-1:0] o_value_out,
    output logic                         o_exception_out,
    output logic [rob_pkg::DEST_W-1:0]   o_dest_out,
    output logic                         o_full_res
);
    import rob_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    rob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // entry storage and result formation
    rob_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_op            (i_op),
        .i_dest_reg      (i_dest_reg),
        .i_tag_in        (i_tag_in),
        .i_result_in     (i_result_in),
        .i_exception_in  (i_exception_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_tag_out       (o_tag_out),
        .o_value_out     (o_value_out),
        .o_exception_out (o_exception_out),
        .o_dest_out      (o_dest_out),
        .o_full_res      (o_full_res)
    );

endmodule

// ===== rtl/rob_ctrl.sv =====
module rob_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  rob_pkg::t_status i_status,
    output rob_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);
    import rob_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands: take a request when idle, finish it once the result register is free
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == S_EXEC) && !i_status.out_busy;
    assign o_in_stall   = (r_state != S_IDLE);

endmodule

// ===== rtl/rob_datapath.sv =====
module rob_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rob_pkg::t_cmd                i_cmd,
    output rob_pkg::t_status             o_status,
    input  logic [rob_pkg::OP_W-1:0]     i_op,
    input  logic [rob_pkg::DEST_W-1:0]   i_dest_reg,
    input  logic [rob_pkg::TAG_W-1:0]    i_tag_in,
    input  logic signed [rob_pkg::VAL_W-1:0] i_result_in,
    input  logic                         i_exception_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ok,
    output logic [rob_pkg::TAG_W-1:0]    o_tag_out,
    output logic signed [rob_pkg::VAL_W-1:0] o_value_out,
    output logic                         o_exception_out,
    output logic [rob_pkg::DEST_W-1:0]   o_dest_out,
    output logic                         o_full_res
);
    import rob_pkg::*;

    // entry memories: {exception, value} and destination
    logic [VAL_W:0]    m_val  [DEPTH];
    logic [DEST_W-1:0] m_dest [DEPTH];

    // per-entry control flops
    t_entry            r_state [DEPTH];
    logic [DEPTH-1:0]  r_done;
    logic [DEPTH-1:0]  r_val_vld;
    logic [DEPTH-1:0]  r_dest_vld;
    t_idx              r_head;
    t_cnt              r_count;
    t_idx              n_head;
    t_cnt              n_count;

    // captured request
    t_op               r_op;
    logic [DEST_W-1:0] r_dest;
    t_idx              r_tag_idx;
    logic              r_tag_ok;
    logic [VAL_W-1:0]  r_res;
    logic              r_exc;

    // registered entry read
    logic [VAL_W:0]    r_rd_val;
    logic [DEST_W-1:0] r_rd_dest;
    logic              r_rd_vvld;
    logic              r_rd_dvld;
    logic              r_rd_done;
    t_entry            r_rd_state;

    // result register
    logic              r_out_valid;
    logic              r_ok;
    logic [TAG_W-1:0]  r_tag_out;
    logic [VAL_W-1:0]  r_value_out;
    logic              r_exc_out;
    logic [DEST_W-1:0] r_dest_out;
    logic              r_full;

    logic [TAGX_W-1:0] tag_x;
    logic              tag_ok;
    t_idx              tag_idx;
    t_idx              rd_idx;
    logic [SUM_W-1:0]  tail_sum;
    t_idx              tail;
    logic [VAL_W:0]    eff_val;
    logic [DEST_W-1:0] eff_dest;

    logic              val_we;
    t_idx              val_addr;
    logic [VAL_W:0]    val_wdata;
    logic              dest_we;
    logic              st_we;
    t_idx              st_addr;
    t_entry            st_wdata;
    logic              done_we;
    t_idx              done_addr;
    logic              done_wdata;

    logic              res_ok;
    logic [TAG_W-1:0]  res_tag;
    logic [VAL_W-1:0]  res_val;
    logic              res_exc;
    logic [DEST_W-1:0] res_dest;

    // tag decode; commit and step work on the head entry
    assign tag_x   = TAGX_W'(i_tag_in);
    assign tag_ok  = (tag_x < TAGX_W'(DEPTH));
    assign tag_idx = tag_x[IDX_W-1:0];
    assign rd_idx  = ((t_op'(i_op) == OP_COMMIT) || (t_op'(i_op) == OP_STEP)) ?
                     r_head : tag_idx;

    // request capture and entry read on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= t_op'(i_op);
            r_dest     <= i_dest_reg;
            r_tag_idx  <= tag_idx;
            r_tag_ok   <= tag_ok;
            r_res      <= i_result_in;
            r_exc      <= i_exception_in;
            r_rd_val   <= m_val[rd_idx];
            r_rd_dest  <= m_dest[rd_idx];
            r_rd_vvld  <= r_val_vld[rd_idx];
            r_rd_dvld  <= r_dest_vld[rd_idx];
            r_rd_done  <= r_done[rd_idx];
            r_rd_state <= r_state[rd_idx];
        end
    end

    // tail = (head + count) mod DEPTH
    always_comb begin
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(DEPTH)) tail_sum = tail_sum - SUM_W'(DEPTH);
        tail = tail_sum[IDX_W-1:0];
    end

    // entries never written read as their reset values
    assign eff_val  = r_rd_vvld ? r_rd_val : '0;
    assign eff_dest = r_rd_dvld ? r_rd_dest : DEST_RESET;

    // operation decode
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        val_we     = 1'b0;
        val_addr   = tail;
        val_wdata  = '0;
        dest_we    = 1'b0;
        st_we      = 1'b0;
        st_addr    = r_head;
        st_wdata   = ST_EMPTY;
        done_we    = 1'b0;
        done_addr  = tail;
        done_wdata = 1'b0;
        res_ok     = 1'b0;
        res_tag    = '0;
        res_val    = '0;
        res_exc    = 1'b0;
        res_dest   = '0;
        unique case (r_op)
            OP_ISSUE: begin
                if (r_count < CNT_W'(DEPTH)) begin
                    val_we   = 1'b1;
                    dest_we  = 1'b1;
                    st_we    = 1'b1;
                    st_addr  = tail;
                    st_wdata = ST_OCCUPIED;
                    done_we  = 1'b1;
                    n_count  = r_count + 1'b1;
                    res_ok   = 1'b1;
                    res_tag  = TAG_W'(TAGX_W'(tail));
                end
            end
            OP_CAPTURE: begin
                if (r_tag_ok) begin
                    val_we     = 1'b1;
                    val_addr   = r_tag_idx;
                    val_wdata  = {r_exc, r_res};
                    done_we    = 1'b1;
                    done_addr  = r_tag_idx;
                    done_wdata = 1'b1;
                end
            end
            OP_COMMIT: begin
                if ((r_count != '0) && (r_rd_state != ST_EMPTY) && r_rd_done) begin
                    res_ok   = 1'b1;
                    res_tag  = TAG_W'(TAGX_W'(r_head));
                    res_val  = eff_val[VAL_W-1:0];
                    res_exc  = eff_val[VAL_W];
                    res_dest = eff_dest;
                    st_we    = 1'b1;
                    st_wdata = ST_RETIRED;
                end
            end
            OP_STEP: begin
                if (r_rd_state == ST_RETIRED) begin
                    st_we  = 1'b1;
                    n_head = (r_head == t_idx'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                    if (r_count != '0) n_count = r_count - 1'b1;
                    res_ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (r_tag_ok) begin
                    res_ok  = r_rd_done;
                    res_val = eff_val[VAL_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && val_we) m_val[val_addr] <= val_wdata;
        if (i_cmd.exec && dest_we) m_dest[tail] <= r_dest;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_state[i] <= ST_EMPTY;
            r_done     <= '0;
            r_val_vld  <= '0;
            r_dest_vld <= '0;
            r_head     <= '0;
            r_count    <= '0;
        end else if (i_cmd.exec) begin
            if (st_we) r_state[st_addr] <= st_wdata;
            if (done_we) r_done[done_addr] <= done_wdata;
            if (val_we) r_val_vld[val_addr] <= 1'b1;
            if (dest_we) r_dest_vld[tail] <= 1'b1;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok        <= res_ok;
            r_tag_out   <= res_tag;
            r_value_out <= res_val;
            r_exc_out   <= res_exc;
            r_dest_out  <= res_dest;
            r_full      <= (n_count == CNT_W'(DEPTH));
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_ok;
    assign o_tag_out         = r_tag_out;
    assign o_value_out       = r_value_out;
    assign o_exception_out   = r_exc_out;
    assign o_dest_out        = r_dest_out;
    assign o_full_res        = r_full;

endmodule

// ===== rtl/rob_checker.sv =====
module rob_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [rob_pkg::OP_W-1:0]     i_op,
    input logic [rob_pkg::DEST_W-1:0]   i_dest_reg,
    input logic [rob_pkg::TAG_W-1:0]    i_tag_in,
    input logic signed [rob_pkg::VAL_W-1:0] i_result_in,
    input logic                         i_exception_in,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_ok,
    input logic [rob_pkg::TAG_W-1:0]    o_tag_out,
    input logic signed [rob_pkg::VAL_W-1:0] o_value_out,
    input logic                         o_exception_out,
    input logic [rob_pkg::DEST_W-1:0]   o_dest_out,
    input logic                         o_full_res
);
    import rob_pkg::*;

    // one request in flight: an accepted request blocks the next one
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous one still in work");

    // reset leaves no result pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("state not cleared by reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped under stall");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        ($stable(o_ok) && $stable(o_tag_out) && $stable(o_value_out) &&
         $stable(o_exception_out) && $stable(o_dest_out) && $stable(o_full_res)))
        else $error("result payload changed under stall");

endmodule

bind reorder_buffer rob_checker u_rob_checker (.*);

// ===== verif/reorder_buffer_tb.sv =====
`timescale 1ns / 1ps

module reorder_buffer_tb;
    import rob_pkg::*;

    // spare operation codes: the block must answer them with zeros, the full flag apart
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int PHASE_ITEMS = 620;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        logic              ok;
        logic [TAG_W-1:0]  tag;
        logic [VAL_W-1:0]  value;
        logic              exc;
        logic [DEST_W-1:0] dest;
        logic              full;
    } rob_result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DEST_W-1:0] dest;
        logic [TAG_W-1:0]  tag;
        logic [VAL_W-1:0]  result;
        logic              exc;
        bit                typed;
        rob_result_t       want;
    } stim_row_t;

    // DUT ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [OP_W-1:0]          i_op = '0;
    logic [DEST_W-1:0]        i_dest_reg = '0;
    logic [TAG_W-1:0]         i_tag_in = '0;
    logic signed [VAL_W-1:0]  i_result_in = '0;
    logic                     i_exception_in = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_ok;
    logic [TAG_W-1:0]         o_tag_out;
    logic signed [VAL_W-1:0]  o_value_out;
    logic                     o_exception_out;
    logic [DEST_W-1:0]        o_dest_out;
    logic                     o_full_res;

    // buffer model state
    t_entry            ent_state [DEPTH];
    logic              ent_done  [DEPTH];
    logic              ent_exc   [DEPTH];
    logic [DEST_W-1:0] ent_dest  [DEPTH];
    logic [VAL_W-1:0]  ent_value [DEPTH];
    int unsigned       head_idx;
    int unsigned       occupancy;

    rob_result_t pending_results[$];
    stim_row_t   dir_table[$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_go = 1'b0;
    logic        hold_on = 1'b0;

    reorder_buffer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_dest_reg     (i_dest_reg),
        .i_tag_in       (i_tag_in),
        .i_result_in    (i_result_in),
        .i_exception_in (i_exception_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ok           (o_ok),
        .o_tag_out      (o_tag_out),
        .o_value_out    (o_value_out),
        .o_exception_out(o_exception_out),
        .o_dest_out     (o_dest_out),
        .o_full_res     (o_full_res)
    );

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("reorder_buffer test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic clear_buffer_model();
        for (int i = 0; i < DEPTH; i++) begin
            ent_state[i] = ST_EMPTY;
            ent_done[i]  = 1'b0;
            ent_exc[i]   = 1'b0;
            ent_dest[i]  = DEST_RESET;
            ent_value[i] = '0;
        end
        head_idx  = 0;
        occupancy = 0;
    endtask

    // apply one request to the buffer model, return the answer it gives
    function automatic rob_result_t apply_request(input logic [OP_W-1:0] op,
                                                  input logic [DEST_W-1:0] dest,
                                                  input logic [TAG_W-1:0] tag,
                                                  input logic [VAL_W-1:0] result,
                                                  input logic exc);
        rob_result_t r;
        int unsigned h;
        int unsigned t;
        r = '{1'b0, '0, '0, 1'b0, '0, 1'b0};
        h = head_idx % DEPTH;
        case (op)
            OP_ISSUE: begin
                if (occupancy < DEPTH) begin
                    t = (h + occupancy) % DEPTH;
                    ent_state[t] = ST_OCCUPIED;
                    ent_exc[t]   = 1'b0;
                    ent_done[t]  = 1'b0;
                    ent_value[t] = '0;
                    ent_dest[t]  = dest;
                    occupancy++;
                    r.ok  = 1'b1;
                    r.tag = t[TAG_W-1:0];
                end
            end
            OP_CAPTURE: begin
                if (tag < DEPTH) begin
                    ent_value[tag] = result;
                    ent_exc[tag]   = exc;
                    ent_done[tag]  = 1'b1;
                end
            end
            OP_COMMIT: begin
                // a retired head that is done is handed out again
                if (occupancy > 0 && ent_state[h] != ST_EMPTY && ent_done[h]) begin
                    r.ok    = 1'b1;
                    r.tag   = h[TAG_W-1:0];
                    r.value = ent_value[h];
                    r.exc   = ent_exc[h];
                    r.dest  = ent_dest[h];
                    ent_state[h] = ST_RETIRED;
                end
            end
            OP_STEP: begin
                if (ent_state[h] == ST_RETIRED) begin
                    ent_state[h] = ST_EMPTY;
                    head_idx = (h + 1) % DEPTH;
                    if (occupancy > 0)
                        occupancy--;
                    r.ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (tag < DEPTH) begin
                    r.ok    = ent_done[tag];
                    r.value = ent_value[tag];
                end
            end
            default: ;
        endcase
        r.full = (occupancy == DEPTH);
        return r;
    endfunction

    // offer one request, with random idle cycles first; predict on acceptance
    task automatic send_request(input stim_row_t row);
        rob_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= row.op;
        i_dest_reg     <= row.dest;
        i_tag_in       <= row.tag;
        i_result_in    <= row.result;
        i_exception_in <= row.exc;
        do @(posedge i_clk); while (o_in_stall);
        r = apply_request(row.op, row.dest, row.tag, row.result, row.exc);
        pending_results.push_back(row.typed ? row.want : r);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // random request, mostly aimed at live entries so commits and steps progress
    function automatic stim_row_t random_request();
        stim_row_t row;
        int unsigned w;
        w = $urandom_range(99);
        row.dest   = DEST_W'($urandom_range(255));
        row.result = $urandom;
        row.exc    = 1'($urandom_range(1));
        row.typed  = 1'b0;
        row.want   = '{1'b0, '0, '0, 1'b0, '0, 1'b0};
        if (occupancy > 0 && $urandom_range(99) < 80)
            row.tag = TAG_W'((head_idx + $urandom_range(occupancy - 1)) % DEPTH);
        else
            row.tag = TAG_W'($urandom_range(7));
        if (w < 24)
            row.op = OP_ISSUE;
        else if (w < 50)
            row.op = OP_CAPTURE;
        else if (w < 70)
            row.op = OP_COMMIT;
        else if (w < 84)
            row.op = OP_STEP;
        else if (w < 97)
            row.op = OP_LOOKUP;
        else
            row.op = OP_W'(OP_SPARE5 + $urandom_range(2));
        return row;
    endfunction

    // long receiver hold-off, counted here
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // result side: check accepted results, then pick next stall
    always @(posedge i_clk) begin : result_check
        rob_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok)
                    report_mismatch($sformatf("ok got %0b want %0b", o_ok, want.ok));
                if (o_tag_out !== want.tag)
                    report_mismatch($sformatf("tag got %0d want %0d", o_tag_out, want.tag));
                if (o_value_out !== want.value)
                    report_mismatch($sformatf("value got %08h want %08h",
                                              o_value_out, want.value));
                if (o_exception_out !== want.exc)
                    report_mismatch($sformatf("exception got %0b want %0b",
                                              o_exception_out, want.exc));
                if (o_dest_out !== want.dest)
                    report_mismatch($sformatf("dest got %02h want %02h",
                                              o_dest_out, want.dest));
                if (o_full_res !== want.full)
                    report_mismatch($sformatf("full got %0b want %0b", o_full_res, want.full));
            end
        end
        i_out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end

    initial begin : stimulus
        stim_row_t zero_row;
        rob_result_t zeros;
        rob_result_t full_reject;

        zeros       = '{1'b0, '0, '0, 1'b0, '0, 1'b0};
        full_reject = '{1'b0, '0, '0, 1'b0, '0, 1'b1};
        zero_row    = '{OP_LOOKUP, '0, '0, '0, 1'b0, 1'b1, zeros};

        // directed table: empty buffer, spare codes, fill, edge values, commit/step
        dir_table.push_back(zero_row);
        dir_table.push_back('{OP_COMMIT, 8'h00, 3'd0, 32'h0, 1'b0, 1'b1, zeros});
        dir_table.push_back('{OP_STEP,   8'h00, 3'd0, 32'h0, 1'b0, 1'b1, zeros});
        dir_table.push_back('{OP_SPARE5, 8'hFF, 3'd7, 32'hFFFFFFFF, 1'b1, 1'b1, zeros});
        dir_table.push_back('{OP_SPARE6, 8'h00, 3'd0, 32'h0, 1'b0, 1'b1, zeros});
        dir_table.push_back('{OP_SPARE7, 8'h5A, 3'd3, 32'h12345678, 1'b1, 1'b1, zeros});
        dir_table.push_back('{OP_ISSUE,  8'h00, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_ISSUE,  8'hFF, 3'd7, 32'hFFFFFFFF, 1'b1, 1'b0, zeros});
        dir_table.push_back('{OP_ISSUE,  8'h5A, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_ISSUE,  8'hA5, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_ISSUE,  8'h01, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_ISSUE,  8'h80, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_ISSUE,  8'h7F, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_ISSUE,  8'hFE, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        // buffer is full now: issue is refused
        dir_table.push_back('{OP_ISSUE,  8'h33, 3'd0, 32'h0, 1'b0, 1'b1, full_reject});
        dir_table.push_back('{OP_CAPTURE, 8'h00, 3'd0, 32'h80000000, 1'b1, 1'b0, zeros});
        dir_table.push_back('{OP_CAPTURE, 8'h00, 3'd7, 32'h7FFFFFFF, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_LOOKUP, 8'h00, 3'd7, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_COMMIT, 8'h00, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        // retired head is given again
        dir_table.push_back('{OP_COMMIT, 8'h00, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_STEP,   8'h00, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        // head not done, then head not retired
        dir_table.push_back('{OP_COMMIT, 8'h00, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_STEP,   8'h00, 3'd0, 32'h0, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_CAPTURE, 8'h00, 3'd1, 32'hFFFFFFFF, 1'b0, 1'b0, zeros});
        dir_table.push_back('{OP_LOOKUP, 8'h00, 3'd3, 32'h0, 1'b0, 1'b0, zeros});

        clear_buffer_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 21;
        recv_idle_pct <= 58;
        @(posedge i_clk);

        foreach (dir_table[i])
            send_request(dir_table[i]);

        // first phase: sender idles lightly, receiver heavily
        repeat (PHASE_ITEMS) send_request(random_request());
        wait_drained();

        // second phase: the other way round
        send_idle_pct <= 58;
        recv_idle_pct <= 21;
        repeat (PHASE_ITEMS) send_request(random_request());

        // third phase: no idling, with a long receiver hold-off to fill the block
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_go <= 1'b1;
        repeat (PHASE_ITEMS) send_request(random_request());

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("reorder_buffer test passed");
        else
            $display("reorder_buffer test failed");
        $finish;
    end

endmodule
